### sv/rar_pkg.sv
// Shared types and codes for the rational arithmetic reduce block.
// No dependencies; used by rational_arithmetic_reduce_top and the testbench.
package rar_pkg;

    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_SUB   = 2'd1,
        K_MUL   = 2'd2,
        K_SCALE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_ZDEN = 2'd1,
        STS_OVF  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_ZCHK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_CHK,
        S_FIN
    } t_state;

endpackage

### sv/rar_gcd.sv
// Binary gcd unit: one shift or subtract-and-halve step per cycle.
// Also strips the common factors of two from copies of both operands.
// Depends on nothing.
module rar_gcd #(
    parameter int P = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [P-1:0] i_x,
    input  logic [P-1:0] i_y,
    output logic         o_done,
    output logic [P-1:0] o_g,
    output logic [P-1:0] o_a,
    output logic [P-1:0] o_b
);

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [P-1:0] r_x, n_x;
    logic [P-1:0] r_y, n_y;
    logic [P-1:0] r_a, n_a;
    logic [P-1:0] r_b, n_b;
    logic [P:0]   w_dxy, w_dyx;

    always_comb begin
        w_dxy  = {1'b0, r_x} - {1'b0, r_y};
        w_dyx  = {1'b0, r_y} - {1'b0, r_x};
        n_busy = r_busy;
        n_done = 1'b0;
        n_x    = r_x;
        n_y    = r_y;
        n_a    = r_a;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_x    = i_x;
            n_y    = i_y;
            n_a    = i_x;
            n_b    = i_y;
        end else if (r_busy) begin
            if (r_x == r_y) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_x[0] && !r_y[0]) begin
                n_x = r_x >> 1;
                n_y = r_y >> 1;
                n_a = r_a >> 1;
                n_b = r_b >> 1;
            end else if (!r_x[0]) begin
                n_x = r_x >> 1;
            end else if (!r_y[0]) begin
                n_y = r_y >> 1;
            end else if (!w_dxy[P]) begin
                n_x = w_dxy[P:1];
            end else begin
                n_y = w_dyx[P:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_done = r_done;
    assign o_g    = r_x;
    assign o_a    = r_a;
    assign o_b    = r_b;

endmodule

### sv/rar_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module rar_div #(
    parameter int P = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [P-1:0] i_dividend,
    input  logic [P-1:0] i_divisor,
    output logic         o_done,
    output logic [P-1:0] o_quot
);

    localparam int CW = $clog2(P);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [P-1:0]  r_rem, n_rem;
    logic [P-1:0]  r_q, n_q;
    logic [P-1:0]  r_dvs, n_dvs;
    logic [P:0]    w_sh, w_diff;

    always_comb begin
        w_sh   = {r_rem, r_q[P-1]};
        w_diff = w_sh - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(P - 1);
            n_rem  = '0;
            n_q    = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!w_diff[P]) begin
                n_rem = w_diff[P-1:0];
                n_q   = {r_q[P-2:0], 1'b1};
            end else begin
                n_rem = w_sh[P-1:0];
                n_q   = {r_q[P-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### sv/rational_arithmetic_reduce_top.sv
// Rational add/sub/mul/scale with gcd reduction: sequencer, shared multiplier,
// adder and result registers. Depends on rar_pkg, rar_gcd and rar_div.
//
//   channel  direction  handshake          payload
//   in       to block   i_valid / o_ready  i_kind i_a_num i_a_den i_b_num i_b_den
//   out      from block o_valid / i_ready  o_r_num o_r_den o_status
//
// One request at a time: a binary gcd loop, then two bit-serial divisions by
// the gcd and the sequencing states; zero denominators and zero numerators
// finish early. The gcd loop and the divider dominate the time a request takes.
// Synchronous active-low reset clears the sequencer and the output valid.
// A result waits in its output register while the next request is taken.
module rational_arithmetic_reduce_top #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_r_num,
    output logic [30:0] o_r_den,
    output logic [1:0]  o_status
);

    localparam int P = 2 * WIDTH;
    localparam logic [P-1:0] LIM = {{(P-1){1'b0}}, 1'b1} << (WIDTH - 1);

    function automatic logic [WIDTH-1:0] f_mag(input logic [31:0] raw);
        logic [WIDTH-1:0] v;
        v = raw[WIDTH-1:0];
        return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
    endfunction

    rar_pkg::t_state  r_state, n_state;
    rar_pkg::t_kind   r_kind, n_kind;
    logic [WIDTH-1:0] r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic             r_ans, n_ans, r_ads, n_ads, r_bns, n_bns, r_bds, n_bds;
    logic             r_sg, n_sg;
    logic [P-1:0]     r_mag, n_mag, r_den, n_den, r_p2, n_p2;
    logic [31:0]      r_res_num, n_res_num;
    logic [30:0]      r_res_den, n_res_den;
    rar_pkg::t_status r_res_sts, n_res_sts;
    logic             r_ovalid, n_ovalid;
    logic [31:0]      r_onum, n_onum;
    logic [30:0]      r_oden, n_oden;
    rar_pkg::t_status r_osts, n_osts;

    logic [WIDTH-1:0] w_an_m, w_ad_m, w_bn_m, w_bd_m;
    logic             w_zden, w_k01;
    logic [WIDTH-1:0] w_ma, w_mb;
    logic [P-1:0]     w_prod, w_sum;
    logic [P:0]       w_d12, w_d21;
    logic             w_s1, w_s2;
    logic [31:0]      w_mag32;
    logic             w_gcd_start, w_gcd_done;
    logic [P-1:0]     w_gcd_g, w_gcd_a, w_gcd_b;
    logic             w_div_start, w_div_done;
    logic [P-1:0]     w_div_dvd, w_div_q;

    assign w_an_m = f_mag(i_a_num);
    assign w_ad_m = f_mag(i_a_den);
    assign w_bn_m = f_mag(i_b_num);
    assign w_bd_m = f_mag(i_b_den);
    assign w_zden = (w_ad_m == '0) ||
                    (i_kind != rar_pkg::K_SCALE && w_bd_m == '0);
    assign w_k01  = (r_kind == rar_pkg::K_ADD) || (r_kind == rar_pkg::K_SUB);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            rar_pkg::S_MUL1: begin
                w_ma = r_an;
                w_mb = w_k01 ? r_bd : r_bn;
            end
            rar_pkg::S_MUL2: begin
                w_ma = w_k01 ? r_bn : r_ad;
                w_mb = w_k01 ? r_ad : r_bd;
            end
            rar_pkg::S_MUL3: begin
                w_ma = r_ad;
                w_mb = r_bd;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod  = P'(w_ma) * P'(w_mb);
    assign w_sum   = r_mag + r_p2;
    assign w_d12   = {1'b0, r_mag} - {1'b0, r_p2};
    assign w_d21   = {1'b0, r_p2} - {1'b0, r_mag};
    assign w_s1    = r_ans ^ r_ads;
    assign w_s2    = r_bns ^ r_bds ^ (r_kind == rar_pkg::K_SUB);
    assign w_mag32 = 32'(r_mag);

    assign w_gcd_start = (r_state == rar_pkg::S_ZCHK) && (r_mag != '0);
    assign w_div_start = ((r_state == rar_pkg::S_GCD) && w_gcd_done) ||
                         ((r_state == rar_pkg::S_DIVN) && w_div_done);
    assign w_div_dvd   = (r_state == rar_pkg::S_GCD) ? w_gcd_a : w_gcd_b;

    rar_gcd #(.P(P)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_x     (r_mag),
        .i_y     (r_den),
        .o_done  (w_gcd_done),
        .o_g     (w_gcd_g),
        .o_a     (w_gcd_a),
        .o_b     (w_gcd_b)
    );

    rar_div #(.P(P)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_gcd_g),
        .o_done     (w_div_done),
        .o_quot     (w_div_q)
    );

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_an      = r_an;
        n_ad      = r_ad;
        n_bn      = r_bn;
        n_bd      = r_bd;
        n_ans     = r_ans;
        n_ads     = r_ads;
        n_bns     = r_bns;
        n_bds     = r_bds;
        n_sg      = r_sg;
        n_mag     = r_mag;
        n_den     = r_den;
        n_p2      = r_p2;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_res_sts = r_res_sts;
        n_ovalid  = r_ovalid && !i_ready;
        n_onum    = r_onum;
        n_oden    = r_oden;
        n_osts    = r_osts;
        o_ready   = 1'b0;
        case (r_state)
            rar_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind = rar_pkg::t_kind'(i_kind);
                    n_an   = w_an_m;
                    n_ad   = w_ad_m;
                    n_bn   = w_bn_m;
                    n_bd   = w_bd_m;
                    n_ans  = i_a_num[WIDTH-1];
                    n_ads  = i_a_den[WIDTH-1];
                    n_bns  = i_b_num[WIDTH-1];
                    n_bds  = i_b_den[WIDTH-1];
                    if (i_kind == rar_pkg::K_SCALE) begin
                        n_sg = i_a_num[WIDTH-1] ^ i_a_den[WIDTH-1] ^ i_b_num[WIDTH-1];
                    end else begin
                        n_sg = i_a_num[WIDTH-1] ^ i_a_den[WIDTH-1] ^
                               i_b_num[WIDTH-1] ^ i_b_den[WIDTH-1];
                    end
                    if (w_zden) begin
                        n_res_num = '0;
                        n_res_den = '0;
                        n_res_sts = rar_pkg::STS_ZDEN;
                        n_state   = rar_pkg::S_FIN;
                    end else begin
                        n_state = rar_pkg::S_MUL1;
                    end
                end
            end
            rar_pkg::S_MUL1: begin
                n_mag   = w_prod;
                n_state = rar_pkg::S_MUL2;
            end
            rar_pkg::S_MUL2: begin
                if (w_k01) begin
                    n_p2    = w_prod;
                    n_state = rar_pkg::S_MUL3;
                end else begin
                    n_den   = (r_kind == rar_pkg::K_MUL) ? w_prod
                                                         : {{WIDTH{1'b0}}, r_ad};
                    n_state = rar_pkg::S_ZCHK;
                end
            end
            rar_pkg::S_MUL3: begin
                n_den   = w_prod;
                n_state = rar_pkg::S_SUM;
            end
            rar_pkg::S_SUM: begin
                if (w_s1 == w_s2) begin
                    n_mag = w_sum;
                    n_sg  = w_s1;
                end else if (!w_d12[P]) begin
                    n_mag = w_d12[P-1:0];
                    n_sg  = w_s1;
                end else begin
                    n_mag = w_d21[P-1:0];
                    n_sg  = w_s2;
                end
                n_state = rar_pkg::S_ZCHK;
            end
            rar_pkg::S_ZCHK: begin
                if (r_mag == '0) begin
                    n_res_num = '0;
                    n_res_den = 31'd1;
                    n_res_sts = rar_pkg::STS_OK;
                    n_state   = rar_pkg::S_FIN;
                end else begin
                    n_state = rar_pkg::S_GCD;
                end
            end
            rar_pkg::S_GCD: begin
                if (w_gcd_done) begin
                    n_state = rar_pkg::S_DIVN;
                end
            end
            rar_pkg::S_DIVN: begin
                if (w_div_done) begin
                    n_mag   = w_div_q;
                    n_state = rar_pkg::S_DIVD;
                end
            end
            rar_pkg::S_DIVD: begin
                if (w_div_done) begin
                    n_den   = w_div_q;
                    n_state = rar_pkg::S_CHK;
                end
            end
            rar_pkg::S_CHK: begin
                if (r_den >= LIM || (r_sg ? (r_mag > LIM) : (r_mag >= LIM))) begin
                    n_res_num = '0;
                    n_res_den = '0;
                    n_res_sts = rar_pkg::STS_OVF;
                end else begin
                    n_res_num = r_sg ? (32'd0 - w_mag32) : w_mag32;
                    n_res_den = 31'(r_den);
                    n_res_sts = rar_pkg::STS_OK;
                end
                n_state = rar_pkg::S_FIN;
            end
            rar_pkg::S_FIN: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_onum   = r_res_num;
                    n_oden   = r_res_den;
                    n_osts   = r_res_sts;
                    n_state  = rar_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rar_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rar_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_kind    <= n_kind;
        r_an      <= n_an;
        r_ad      <= n_ad;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_ans     <= n_ans;
        r_ads     <= n_ads;
        r_bns     <= n_bns;
        r_bds     <= n_bds;
        r_sg      <= n_sg;
        r_mag     <= n_mag;
        r_den     <= n_den;
        r_p2      <= n_p2;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_res_sts <= n_res_sts;
        r_onum    <= n_onum;
        r_oden    <= n_oden;
        r_osts    <= n_osts;
    end

    assign o_valid  = r_ovalid;
    assign o_r_num  = r_onum;
    assign o_r_den  = r_oden;
    assign o_status = r_osts;

    a_zden_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && w_zden) |=>
        (r_state == rar_pkg::S_FIN && r_res_sts == rar_pkg::STS_ZDEN))
        else $error("zero denominator request not flagged");

    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rar_pkg::STS_OK) |-> (o_r_den != '0))
        else $error("ok result with zero denominator");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rar_pkg::STS_OK) |-> (o_r_num == '0 && o_r_den == '0))
        else $error("error result with nonzero fields");

    a_gcd_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gcd_start |-> (r_mag != '0 && r_den != '0))
        else $error("gcd started on a zero operand");

    a_div_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == rar_pkg::S_DIVN || r_state == rar_pkg::S_DIVD))
        else $error("divider finished outside a division step");

endmodule

### dv/tb_top.sv
// Self-checking testbench for rational_arithmetic_reduce_top: a directed table, then
// random fraction requests under varying back-pressure, checked against a local predictor.
// Depends on rar_pkg and the rational_arithmetic_reduce_top RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int P_WIDTH        = 32;
    localparam int LATENCY        = 8 * P_WIDTH + 12;
    localparam int HOLD_CYCLES    = 600;
    localparam int RAND_PER_PHASE = 600;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int N_DIR          = 25;

    typedef struct packed {
        rar_pkg::t_kind kind;
        logic [31:0]    a_num;
        logic [31:0]    a_den;
        logic [31:0]    b_num;
        logic [31:0]    b_den;
    } t_frac_req;

    typedef struct packed {
        logic [31:0]      num;
        logic [30:0]      den;
        rar_pkg::t_status sts;
    } t_frac_res;

    typedef struct packed {
        t_frac_req req;
        logic      typed;
        t_frac_res res;
    } t_frac_row;

    // typed rows carry their result; the others go through the predictor
    localparam t_frac_row DIR_ROWS [N_DIR] = '{
        '{'{rar_pkg::K_ADD,   32'd1, 32'd2, 32'd1, 32'd3}, 1'b1,
          '{32'd5, 31'd6, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_SUB,   32'd1, 32'd2, 32'd1, 32'd2}, 1'b1,
          '{32'd0, 31'd1, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_MUL,   32'd2, 32'd3, 32'd3, 32'd4}, 1'b1,
          '{32'd1, 31'd2, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_SCALE, 32'd3, 32'd4, 32'd2, 32'd0}, 1'b1,
          '{32'd3, 31'd2, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_ADD,   32'd1, 32'd0, 32'd1, 32'd3}, 1'b1,
          '{32'd0, 31'd0, rar_pkg::STS_ZDEN}},
        '{'{rar_pkg::K_MUL,   32'd1, 32'd2, 32'd1, 32'd0}, 1'b1,
          '{32'd0, 31'd0, rar_pkg::STS_ZDEN}},
        '{'{rar_pkg::K_SCALE, 32'd1, 32'd0, 32'd5, 32'd0}, 1'b1,
          '{32'd0, 31'd0, rar_pkg::STS_ZDEN}},
        '{'{rar_pkg::K_SUB,   32'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
          '{32'd0, 31'd0, rar_pkg::STS_ZDEN}},
        '{'{rar_pkg::K_ADD,   32'd0, 32'd5, 32'd0, 32'hffff_fff9}, 1'b1,
          '{32'd0, 31'd1, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_MUL,   32'd1, 32'hffff_fffe, 32'd1, 32'd3}, 1'b1,
          '{32'hffff_ffff, 31'd6, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_SCALE, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1}, 1'b1,
          '{32'd0, 31'd0, rar_pkg::STS_OVF}},
        '{'{rar_pkg::K_SCALE, 32'h8000_0000, 32'd1, 32'd1, 32'd0}, 1'b1,
          '{32'h8000_0000, 31'd1, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_MUL,   32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1}, 1'b1,
          '{32'd0, 31'd0, rar_pkg::STS_OVF}},
        '{'{rar_pkg::K_ADD,   32'd1, 32'h7fff_ffff, 32'd1, 32'd2}, 1'b1,
          '{32'd0, 31'd0, rar_pkg::STS_OVF}},
        '{'{rar_pkg::K_MUL,   32'd1, 32'h8000_0000, 32'd1, 32'd1}, 1'b1,
          '{32'd0, 31'd0, rar_pkg::STS_OVF}},
        '{'{rar_pkg::K_SCALE, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd0}, 1'b1,
          '{32'd1, 31'd1, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_SUB,   32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1}, 1'b1,
          '{32'd0, 31'd0, rar_pkg::STS_OVF}},
        '{'{rar_pkg::K_ADD,   32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            32'hffff_ffff}, 1'b1,
          '{32'd2, 31'd1, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_MUL,   32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffe,
            32'h7fff_ffff}, 1'b1,
          '{32'd1, 31'd1, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_SCALE, 32'd5, 32'd10, 32'd0, 32'd0}, 1'b1,
          '{32'd0, 31'd1, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_SUB,   32'd6, 32'd4, 32'd9, 32'd6}, 1'b1,
          '{32'd0, 31'd1, rar_pkg::STS_OK}},
        '{'{rar_pkg::K_SUB,   32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000}, 1'b0, '0},
        '{'{rar_pkg::K_ADD,   32'h1234_5678, 32'h0fed_cba9, 32'hedcb_a987,
            32'h0001_2345}, 1'b0, '0},
        '{'{rar_pkg::K_MUL,   32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'h0000_ffff,
            32'hffff_0000}, 1'b0, '0},
        '{'{rar_pkg::K_SCALE, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
            32'hffff_ffff}, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_kind;
    logic [31:0] i_a_num;
    logic [31:0] i_a_den;
    logic [31:0] i_b_num;
    logic [31:0] i_b_den;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_r_num;
    logic [30:0] o_r_den;
    logic [1:0]  o_status;

    t_frac_res awaited_fractions [$];
    int        fail_cnt;
    int        report_cnt;
    int        cycle_cnt;
    int        phase;
    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        hold_done;

    rational_arithmetic_reduce_top #(
        .WIDTH(P_WIDTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_kind),
        .i_a_num  (i_a_num),
        .i_a_den  (i_a_den),
        .i_b_num  (i_b_num),
        .i_b_den  (i_b_den),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_r_num  (o_r_num),
        .o_r_den  (o_r_den),
        .o_status (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void to_sign_mag(input logic [31:0] raw, output bit neg,
                                        output bit [63:0] mag);
        bit [63:0] mask;
        bit [63:0] sbit;
        bit [63:0] v;
        mask = (64'd1 << P_WIDTH) - 64'd1;
        sbit = 64'd1 << (P_WIDTH - 1);
        v    = {32'd0, raw} & mask;
        neg  = (v & sbit) != 0;
        mag  = neg ? ((~v + 64'd1) & mask) : v;
    endfunction

    function automatic t_frac_res rational_reduce(t_frac_req r);
        bit [63:0] sbit;
        bit [63:0] an, ad, bn, bd;
        bit [63:0] m1, m2, mag, den, x, y, t;
        bit        an_s, ad_s, bn_s, bd_s, s1, s2, sg;
        t_frac_res res;
        sbit = 64'd1 << (P_WIDTH - 1);
        res  = '0;
        to_sign_mag(r.a_num, an_s, an);
        to_sign_mag(r.a_den, ad_s, ad);
        to_sign_mag(r.b_num, bn_s, bn);
        to_sign_mag(r.b_den, bd_s, bd);
        if (ad == 0 || (r.kind != rar_pkg::K_SCALE && bd == 0)) begin
            res.sts = rar_pkg::STS_ZDEN;
            return res;
        end
        case (r.kind)
            rar_pkg::K_ADD, rar_pkg::K_SUB: begin
                s1  = an_s ^ ad_s;
                s2  = bn_s ^ bd_s;
                m1  = an * bd;
                m2  = bn * ad;
                den = ad * bd;
                if (r.kind == rar_pkg::K_SUB) s2 = !s2;
                if (s1 == s2) begin
                    mag = m1 + m2;
                    sg  = s1;
                end else if (m1 >= m2) begin
                    mag = m1 - m2;
                    sg  = s1;
                end else begin
                    mag = m2 - m1;
                    sg  = s2;
                end
            end
            rar_pkg::K_MUL: begin
                mag = an * bn;
                den = ad * bd;
                sg  = (an_s ^ ad_s) ^ (bn_s ^ bd_s);
            end
            default: begin
                mag = an * bn;
                den = ad;
                sg  = (an_s ^ ad_s) ^ bn_s;
            end
        endcase
        if (mag == 0) begin
            res.den = 31'd1;
            return res;
        end
        x = mag;
        y = den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        mag = mag / x;
        den = den / x;
        if (den > sbit - 1 || (sg ? mag > sbit : mag > sbit - 1)) begin
            res.sts = rar_pkg::STS_OVF;
            return res;
        end
        mag     = sg ? -mag : mag;
        res.num = mag[31:0];
        res.den = den[30:0];
        return res;
    endfunction

    // mostly small values so results reduce and fit; some full-range and corner values
    function automatic logic [31:0] rand_operand();
        int unsigned sel;
        logic [31:0] v;
        sel = $urandom_range(99);
        if (sel < 45) begin
            v = $urandom_range(100) - 32'd50;
        end else if (sel < 60) begin
            v = $urandom_range(65535) - 32'd32768;
        end else if (sel < 80) begin
            v = $urandom();
        end else if (sel < 90) begin
            v = $urandom() >> $urandom_range(31);
            if ($urandom_range(1) == 1) v = -v;
        end else begin
            case ($urandom_range(5))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'hffff_ffff;
                3: v = 32'd0;
                4: v = 32'd1;
                default: v = 32'h8000_0001;
            endcase
        end
        return v;
    endfunction

    // entered and left at a falling edge
    task automatic send_req(t_frac_req r, bit typed, t_frac_res typed_res);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_kind  <= r.kind;
        i_a_num <= r.a_num;
        i_a_den <= r.a_den;
        i_b_num <= r.b_num;
        i_b_den <= r.b_den;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        awaited_fractions.push_back(typed ? typed_res : rational_reduce(r));
        @(negedge i_clk);
    endtask

    initial begin
        hold_done = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase == 2 && !hold_done) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frac_res exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_fractions.size() == 0) begin
                fail_cnt++;
                if (report_cnt < 10) begin
                    report_cnt++;
                    $display("unexpected result %h/%h status %0d", o_r_num, o_r_den, o_status);
                end
            end else begin
                exp_res = awaited_fractions.pop_front();
                if (o_r_num !== exp_res.num || o_r_den !== exp_res.den
                    || o_status !== exp_res.sts) begin
                    fail_cnt++;
                    if (report_cnt < 10) begin
                        report_cnt++;
                        $display("mismatch: expected %h/%h status %0d, got %h/%h status %0d",
                                 exp_res.num, exp_res.den, exp_res.sts,
                                 o_r_num, o_r_den, o_status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_frac_req   rq;
        int unsigned k;
        fail_cnt    = 0;
        report_cnt  = 0;
        cycle_cnt   = 0;
        phase       = 0;
        tx_idle_pct = 12;
        rx_idle_pct = 76;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = rar_pkg::K_ADD;
        i_a_num     = '0;
        i_a_den     = '0;
        i_b_num     = '0;
        i_b_den     = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            send_req(DIR_ROWS[r].req, DIR_ROWS[r].typed, DIR_ROWS[r].res);
        end

        for (int ph = 0; ph < 3; ph++) begin
            phase       = ph;
            tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 76 : 0;
            rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 12 : 0;
            repeat (RAND_PER_PHASE) begin
                rq.kind  = rar_pkg::t_kind'($urandom_range(3));
                rq.a_num = rand_operand();
                rq.a_den = rand_operand();
                rq.b_num = rand_operand();
                rq.b_den = rand_operand();
                // second fraction a multiple of the first: cancels on subtract
                if ($urandom_range(99) < 15) begin
                    k        = $urandom_range(20, 1);
                    rq.b_num = rq.a_num * k;
                    rq.b_den = rq.a_den * k;
                    if ($urandom_range(1) == 1) begin
                        rq.b_num = -rq.b_num;
                        rq.b_den = -rq.b_den;
                    end
                end
                send_req(rq, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (awaited_fractions.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 32) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
